>>> sv/drop_alarm_detector_defines.svh
// Assertion macros shared by the drop alarm detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DROP_ALARM_DETECTOR_DEFINES_SVH
`define DROP_ALARM_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DAD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DAD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dad_pkg.sv
// Types and constants of the drop alarm detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package dad_pkg;

    localparam int LEVEL_BITS    = 34;
    localparam int DUR_BITS      = 24;
    localparam int COUNT_BITS    = 8;
    localparam int CFG_DATA_BITS = 34;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [2:0] {
        REG_FREEFALL_LEVEL,
        REG_IMPACT_LEVEL,
        REG_FREEFALL_TIME,
        REG_IMPACT_WINDOW,
        REG_STILL_LOW,
        REG_STILL_HIGH,
        REG_PICKUP_WINDOW,
        REG_PICKUP_COUNT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DROP  = 2'd1,
        EV_CLEAR = 2'd2
    } t_event;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] freefall_level_sq;
        logic [LEVEL_BITS-1:0] impact_level_sq;
        logic [DUR_BITS-1:0]   freefall_time_us;
        logic [DUR_BITS-1:0]   impact_window_us;
        logic [LEVEL_BITS-1:0] still_low_sq;
        logic [LEVEL_BITS-1:0] still_high_sq;
        logic [DUR_BITS-1:0]   pickup_window_us;
        logic [COUNT_BITS-1:0] pickup_count;
    } t_cfg;

    // Result of comparing one sample's squared magnitude with the thresholds.
    typedef struct packed {
        logic freefall;
        logic impact;
        logic motion;
    } t_class;

    localparam t_cfg CFG_RESET = '{
        freefall_level_sq: LEVEL_BITS'(1009115),
        impact_level_sq:   LEVEL_BITS'(39418330),
        freefall_time_us:  DUR_BITS'(150000),
        impact_window_us:  DUR_BITS'(500000),
        still_low_sq:      LEVEL_BITS'(4525661),
        still_high_sq:     LEVEL_BITS'(8383153),
        pickup_window_us:  DUR_BITS'(2000000),
        pickup_count:      COUNT_BITS'(20)
    };

endpackage

`default_nettype wire

>>> sv/dad_front.sv
// Front end: accepts samples, squares the axes and classifies the magnitude.
// Depends on dad_pkg; feeds the queue in front of dad_back.
`default_nettype none

module dad_front #(
    parameter int TIME_BITS  = 48,
    parameter int ACCEL_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dad_pkg::t_cfg                i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_x,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_y,
    input  wire logic signed [ACCEL_BITS-1:0] i_accel_z,
    input  wire logic [TIME_BITS-1:0]         i_sample_time_us,
    input  wire logic                         i_full,
    output logic                              o_push,
    output dad_pkg::t_class                   o_class,
    output logic [TIME_BITS-1:0]              o_time
);
    import dad_pkg::*;

    localparam int SQ_BITS  = 2 * ACCEL_BITS;
    localparam int SUM_BITS = (SQ_BITS > LEVEL_BITS) ? SQ_BITS : LEVEL_BITS;

    logic [ACCEL_BITS-1:0] abs_x, abs_y, abs_z;
    logic [SQ_BITS-1:0]    sq_x, sq_y, sq_z;
    logic [SQ_BITS-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [TIME_BITS-1:0]  r_time;
    logic                  r_vld;
    logic [SUM_BITS-1:0]   mag_sq;
    logic                  accept;

    // The most negative value maps onto its magnitude as an unsigned number.
    assign abs_x = i_accel_x[ACCEL_BITS-1] ? ACCEL_BITS'(-i_accel_x) : ACCEL_BITS'(i_accel_x);
    assign abs_y = i_accel_y[ACCEL_BITS-1] ? ACCEL_BITS'(-i_accel_y) : ACCEL_BITS'(i_accel_y);
    assign abs_z = i_accel_z[ACCEL_BITS-1] ? ACCEL_BITS'(-i_accel_z) : ACCEL_BITS'(i_accel_z);

    assign sq_x = SQ_BITS'(abs_x) * SQ_BITS'(abs_x);
    assign sq_y = SQ_BITS'(abs_y) * SQ_BITS'(abs_y);
    assign sq_z = SQ_BITS'(abs_z) * SQ_BITS'(abs_z);

    assign o_ready = !r_vld || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (accept) begin
            r_sq_x <= sq_x;
            r_sq_y <= sq_y;
            r_sq_z <= sq_z;
            r_time <= i_sample_time_us;
        end
    end

    assign mag_sq = SUM_BITS'(r_sq_x) + SUM_BITS'(r_sq_y) + SUM_BITS'(r_sq_z);

    always_comb begin
        o_class.freefall = mag_sq < SUM_BITS'(i_cfg.freefall_level_sq);
        o_class.impact   = mag_sq > SUM_BITS'(i_cfg.impact_level_sq);
        o_class.motion   = (mag_sq < SUM_BITS'(i_cfg.still_low_sq))
                        || (mag_sq > SUM_BITS'(i_cfg.still_high_sq));
    end

    assign o_time = r_time;

endmodule

`default_nettype wire

>>> sv/dad_fifo.sv
// Short queue between the classifying front end and the state update.
// Depends on dad_pkg for its depth and on the assertion macro header.
`default_nettype none
`include "drop_alarm_detector_defines.svh"

module dad_fifo #(
    parameter int WIDTH = 51
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_vld,
    output logic [WIDTH-1:0]      o_data
);
    import dad_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full = r_count == CNT_BITS'(QUEUE_DEPTH);
    assign o_vld  = r_count != '0;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `DAD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into a full queue")
    `DAD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, !o_vld, !i_pop, "pop from an empty queue")

endmodule

`default_nettype wire

>>> sv/dad_back.sv
// Back end: freefall, impact and pickup state, and the registered result.
// Depends on dad_pkg and on the assertion macro header.
`default_nettype none
`include "drop_alarm_detector_defines.svh"

module dad_back #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dad_pkg::t_cfg        i_cfg,
    input  wire logic                 i_entry_vld,
    input  wire dad_pkg::t_class      i_class,
    input  wire logic [TIME_BITS-1:0] i_time,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_drop_event,
    output logic                      o_drop_latched
);
    import dad_pkg::*;

    logic                  r_latched, n_latched;
    logic                  r_ff_active, n_ff_active;
    logic [TIME_BITS-1:0]  r_ff_start, n_ff_start;
    logic [TIME_BITS-1:0]  r_deadline, n_deadline;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIME_BITS-1:0]  r_win_start, n_win_start;
    logic                  r_out_vld;
    t_event                r_event, n_event;
    logic                  r_out_latched;

    logic [TIME_BITS-1:0]  ref_time, diff, sat_deadline;
    logic [DUR_BITS-1:0]   limit;
    logic                  over;
    logic [TIME_BITS:0]    dl_sum;
    logic [COUNT_BITS-1:0] count_inc;

    assign o_pop = i_entry_vld && (!r_out_vld || i_ready);

    // One elapsed-time check serves both the freefall and the pickup window.
    assign ref_time = r_latched ? r_win_start : r_ff_start;
    assign limit    = r_latched ? i_cfg.pickup_window_us : i_cfg.freefall_time_us;
    assign diff     = i_time - ref_time;
    assign over     = (i_time >= ref_time) && (diff > TIME_BITS'(limit));

    assign dl_sum       = (TIME_BITS + 1)'(i_time) + (TIME_BITS + 1)'(i_cfg.impact_window_us);
    assign sat_deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

    assign count_inc = (i_class.motion && r_count != '1) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_latched   = r_latched;
        n_ff_active = r_ff_active;
        n_ff_start  = r_ff_start;
        n_deadline  = r_deadline;
        n_count     = r_count;
        n_win_start = r_win_start;
        n_event     = EV_NONE;
        if (!r_latched) begin
            if (i_class.freefall) begin
                if (!r_ff_active) begin
                    n_ff_active = 1'b1;
                    n_ff_start  = i_time;
                end else if (over) begin
                    n_deadline = sat_deadline;
                end
            end else begin
                n_ff_active = 1'b0;
                n_ff_start  = '0;
                if (i_class.impact && i_time < r_deadline) begin
                    n_latched   = 1'b1;
                    n_event     = EV_DROP;
                    n_count     = '0;
                    n_win_start = i_time;
                end
            end
        end else begin
            n_count = count_inc;
            if (over) begin
                if (count_inc >= i_cfg.pickup_count) begin
                    n_latched  = 1'b0;
                    n_event    = EV_CLEAR;
                    n_deadline = '0;
                end
                n_count     = '0;
                n_win_start = i_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= 1'b0;
            r_ff_active <= 1'b0;
            r_ff_start  <= '0;
            r_deadline  <= '0;
            r_count     <= '0;
            r_win_start <= '0;
            r_out_vld   <= 1'b0;
        end else if (o_pop) begin
            r_latched   <= n_latched;
            r_ff_active <= n_ff_active;
            r_ff_start  <= n_ff_start;
            r_deadline  <= n_deadline;
            r_count     <= n_count;
            r_win_start <= n_win_start;
            r_out_vld   <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (o_pop) begin
            r_event       <= n_event;
            r_out_latched <= n_latched;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_drop_event   = r_event;
    assign o_drop_latched = r_out_latched;

    `DAD_ASSERT_IMP(a_drop_sets_latch, i_clk, i_rst_n, r_out_vld && r_event == EV_DROP, r_out_latched, "drop event without latch")
    `DAD_ASSERT_IMP(a_latch_rise_event, i_clk, i_rst_n, $rose(r_latched), r_out_vld && r_event == EV_DROP, "latch set without drop event")

endmodule

`default_nettype wire

>>> sv/drop_alarm_detector.sv
// A sample passes the front-end register and the queue to the back-end register.
// One sample per cycle while the queue has room; one pop per cycle when unstalled.
// A four-entry queue lets the front end keep accepting while results are stalled.
// Reset (synchronous, active low) loads register defaults and clears control state.
// Top level: configuration registers, front end, queue and back end.
// Depends on dad_pkg, dad_front, dad_fifo and dad_back.
`default_nettype none

module drop_alarm_detector #(
    parameter int TIME_BITS  = 48,
    parameter int ACCEL_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire dad_pkg::t_cfg_idx                    i_cfg_idx,
    input  wire logic [dad_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [ACCEL_BITS-1:0]         i_accel_x,
    input  wire logic signed [ACCEL_BITS-1:0]         i_accel_y,
    input  wire logic signed [ACCEL_BITS-1:0]         i_accel_z,
    input  wire logic [TIME_BITS-1:0]                 i_sample_time_us,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [1:0]                                o_drop_event,
    output logic                                      o_drop_latched
);
    import dad_pkg::*;

    localparam int CLASS_BITS = $bits(t_class);
    localparam int ENTRY_BITS = CLASS_BITS + TIME_BITS;

    t_cfg                  r_cfg;
    logic                  push, pop, full, q_vld;
    t_class                f_class, b_class;
    logic [TIME_BITS-1:0]  f_time, b_time;
    logic [ENTRY_BITS-1:0] q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FREEFALL_LEVEL: r_cfg.freefall_level_sq <= i_cfg_data[LEVEL_BITS-1:0];
                REG_IMPACT_LEVEL:   r_cfg.impact_level_sq   <= i_cfg_data[LEVEL_BITS-1:0];
                REG_FREEFALL_TIME:  r_cfg.freefall_time_us  <= i_cfg_data[DUR_BITS-1:0];
                REG_IMPACT_WINDOW:  r_cfg.impact_window_us  <= i_cfg_data[DUR_BITS-1:0];
                REG_STILL_LOW:      r_cfg.still_low_sq      <= i_cfg_data[LEVEL_BITS-1:0];
                REG_STILL_HIGH:     r_cfg.still_high_sq     <= i_cfg_data[LEVEL_BITS-1:0];
                REG_PICKUP_WINDOW:  r_cfg.pickup_window_us  <= i_cfg_data[DUR_BITS-1:0];
                REG_PICKUP_COUNT:   r_cfg.pickup_count      <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    dad_front #(
        .TIME_BITS  (TIME_BITS),
        .ACCEL_BITS (ACCEL_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_sample_time_us (i_sample_time_us),
        .i_full           (full),
        .o_push           (push),
        .o_class          (f_class),
        .o_time           (f_time)
    );

    dad_fifo #(
        .WIDTH (ENTRY_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_class, f_time}),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_data  (q_out)
    );

    assign b_class = t_class'(q_out[ENTRY_BITS-1:TIME_BITS]);
    assign b_time  = q_out[TIME_BITS-1:0];

    dad_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_entry_vld    (q_vld),
        .i_class        (b_class),
        .i_time         (b_time),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drop_event   (o_drop_event),
        .o_drop_latched (o_drop_latched)
    );

endmodule

`default_nettype wire

>>> dv/tb_drop_alarm_detector.sv
// Self-checking testbench for the drop alarm detector: a scoreboard class predicts each
// sample's event and latch value, and plain tasks drive samples and configuration writes.
// Depends on dad_pkg and drop_alarm_detector.
module tb_drop_alarm_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import dad_pkg::*;

    localparam int TIME_W = 48;
    localparam int ACC_W = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [TIME_W-1:0] TMAX = '1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [DUR_BITS-1:0] DUR_MAX = '1;

    typedef struct {
        t_event ev;
        logic   latched;
    } t_outcome;

    typedef enum {SK_FREEFALL, SK_IMPACT, SK_STILL, SK_MOTION, SK_ANY} t_sample_kind;
    typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_BLOCKY} t_rx_mode;

    class drop_scoreboard;
        t_cfg              cfg;
        logic              is_latched;
        logic              in_freefall;
        logic [TIME_W-1:0] fall_start;
        logic [TIME_W-1:0] impact_deadline;
        logic [TIME_W-1:0] window_start;
        logic [7:0]        motion_count;
        t_outcome          pending[$];
        int                errors;

        function new();
            cfg = CFG_RESET;
            is_latched = 1'b0;
            in_freefall = 1'b0;
            fall_start = '0;
            impact_deadline = '0;
            window_start = '0;
            motion_count = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_FREEFALL_LEVEL: cfg.freefall_level_sq = data[LEVEL_BITS-1:0];
                REG_IMPACT_LEVEL:   cfg.impact_level_sq = data[LEVEL_BITS-1:0];
                REG_FREEFALL_TIME:  cfg.freefall_time_us = data[DUR_BITS-1:0];
                REG_IMPACT_WINDOW:  cfg.impact_window_us = data[DUR_BITS-1:0];
                REG_STILL_LOW:      cfg.still_low_sq = data[LEVEL_BITS-1:0];
                REG_STILL_HIGH:     cfg.still_high_sq = data[LEVEL_BITS-1:0];
                REG_PICKUP_WINDOW:  cfg.pickup_window_us = data[DUR_BITS-1:0];
                REG_PICKUP_COUNT:   cfg.pickup_count = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Time that runs backwards counts as no time at all.
        static function logic [TIME_W-1:0] span(logic [TIME_W-1:0] now,
                                                logic [TIME_W-1:0] since);
            return (now >= since) ? now - since : '0;
        endfunction

        function void note_sample(logic signed [ACC_W-1:0] ax, logic signed [ACC_W-1:0] ay,
                                  logic signed [ACC_W-1:0] az, logic [TIME_W-1:0] now);
            logic [ACC_W:0]        mx, my, mz;
            logic [LEVEL_BITS-1:0] mag_sq;
            logic [TIME_W-1:0]     window;
            t_outcome              o;
            mx = ax[ACC_W-1] ? -{1'b1, ax} : {1'b0, ax};
            my = ay[ACC_W-1] ? -{1'b1, ay} : {1'b0, ay};
            mz = az[ACC_W-1] ? -{1'b1, az} : {1'b0, az};
            mag_sq = mx * mx + my * my + mz * mz;
            window = TIME_W'(cfg.impact_window_us);
            o.ev = EV_NONE;
            if (!is_latched) begin
                if (mag_sq < cfg.freefall_level_sq) begin
                    if (!in_freefall) begin
                        in_freefall = 1'b1;
                        fall_start = now;
                    end else if (span(now, fall_start) > TIME_W'(cfg.freefall_time_us)) begin
                        impact_deadline = (now > TMAX - window) ? TMAX : now + window;
                    end
                end else begin
                    in_freefall = 1'b0;
                    fall_start = '0;
                    if (mag_sq > cfg.impact_level_sq && now < impact_deadline) begin
                        is_latched = 1'b1;
                        o.ev = EV_DROP;
                        motion_count = '0;
                        window_start = now;
                    end
                end
            end else begin
                if ((mag_sq < cfg.still_low_sq || mag_sq > cfg.still_high_sq)
                        && motion_count != 8'hFF) begin
                    motion_count++;
                end
                if (span(now, window_start) > TIME_W'(cfg.pickup_window_us)) begin
                    if (motion_count >= cfg.pickup_count) begin
                        is_latched = 1'b0;
                        o.ev = EV_CLEAR;
                        impact_deadline = '0;
                    end
                    motion_count = '0;
                    window_start = now;
                end
            end
            o.latched = is_latched;
            pending.push_back(o);
        endfunction

        function void check_result(logic [1:0] ev, logic lat);
            t_outcome o;
            if (pending.size() == 0) begin
                $error("drop_event: expected nothing, actual %0d (drop_latched %0d)", ev, lat);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (ev !== o.ev) begin
                $error("drop_event: expected %0d, actual %0d", o.ev, ev);
                errors++;
            end
            if (lat !== o.latched) begin
                $error("drop_latched: expected %0d, actual %0d", o.latched, lat);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    t_cfg_idx                     i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [ACC_W-1:0]      i_accel_x;
    logic signed [ACC_W-1:0]      i_accel_y;
    logic signed [ACC_W-1:0]      i_accel_z;
    logic [TIME_W-1:0]            i_sample_time_us;
    logic                         o_valid;
    logic                         i_ready;
    logic [1:0]                   o_drop_event;
    logic                         o_drop_latched;

    drop_scoreboard    sb = new();
    logic [TIME_W-1:0] cur_time = '0;
    int                tick_lo = 1000;
    int                tick_hi = 2000;
    int                odd_time_permille = 30;
    int                items_sent = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;

    drop_alarm_detector i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_sample_time_us (i_sample_time_us),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drop_event     (o_drop_event),
        .o_drop_latched   (o_drop_latched)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        t_rx_mode mode;
        int       mode_left;
        int       hold;
        int       cycle_no;
        logic     level;
        mode = RX_FREE;
        mode_left = 0;
        hold = 0;
        cycle_no = 0;
        level = 1'b1;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            cycle_no++;
            case (mode)
                RX_FREE:   i_ready = 1'b1;
                RX_RANDOM: i_ready = ($urandom_range(0, 3) != 0);
                RX_SPARSE: i_ready = (cycle_no % 4 == 0);
                default: begin
                    if (hold == 0) begin
                        level = !level;
                        hold = level ? $urandom_range(1, 5) : $urandom_range(1, 20);
                    end
                    hold--;
                    i_ready = level;
                end
            endcase
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                sb.check_result(o_drop_event, o_drop_latched);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is accepted.
    task automatic send_sample(logic signed [ACC_W-1:0] x, logic signed [ACC_W-1:0] y,
                               logic signed [ACC_W-1:0] z, logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid = 1'b1;
        i_accel_x = x;
        i_accel_y = y;
        i_accel_z = z;
        i_sample_time_us = t;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x, y, z, t);
        burst_left--;
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [ACC_W-1:0] signed_axis(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        return ($urandom_range(0, 1) == 1) ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    task automatic send_kind(t_sample_kind kind);
        logic signed [ACC_W-1:0] v[3];
        int                      lead;
        lead = $urandom_range(0, 2);
        case (kind)
            SK_FREEFALL: foreach (v[i]) v[i] = signed_axis(0, 300);
            SK_IMPACT: begin
                foreach (v[i]) v[i] = ACC_W'($urandom);
                v[lead] = signed_axis(6500, 32767);
            end
            SK_STILL: begin
                foreach (v[i]) v[i] = signed_axis(0, 100);
                v[lead] = signed_axis(2200, 2850);
            end
            SK_MOTION: begin
                if ($urandom_range(0, 1) == 1) begin
                    foreach (v[i]) v[i] = signed_axis(0, 1200);
                end else begin
                    foreach (v[i]) v[i] = signed_axis(0, 32767);
                    v[lead] = signed_axis(3000, 32767);
                end
            end
            default: begin
                foreach (v[i]) begin
                    case ($urandom_range(0, 7))
                        0: v[i] = 16'sh8000;
                        1: v[i] = 16'sh7FFF;
                        2: v[i] = '0;
                        default: v[i] = ACC_W'($urandom);
                    endcase
                end
            end
        endcase
        if ($urandom_range(0, 999) < odd_time_permille) begin
            case ($urandom_range(0, 3))
                0, 1: cur_time -= TIME_W'($urandom_range(1, 3 * tick_hi));
                2: cur_time = TMAX - TIME_W'($urandom_range(0, 4 * tick_hi));
                default: cur_time = TIME_W'({$urandom, $urandom});
            endcase
        end else begin
            cur_time += TIME_W'($urandom_range(tick_lo, tick_hi));
        end
        send_sample(v[0], v[1], v[2], cur_time);
    endtask

    // Waits until every result has come back, so that registers may be written.
    task automatic settle();
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_config(t_cfg c);
        settle();
        set_reg(REG_FREEFALL_LEVEL, CFG_DATA_BITS'(c.freefall_level_sq));
        set_reg(REG_IMPACT_LEVEL, CFG_DATA_BITS'(c.impact_level_sq));
        set_reg(REG_FREEFALL_TIME, CFG_DATA_BITS'(c.freefall_time_us));
        set_reg(REG_IMPACT_WINDOW, CFG_DATA_BITS'(c.impact_window_us));
        set_reg(REG_STILL_LOW, CFG_DATA_BITS'(c.still_low_sq));
        set_reg(REG_STILL_HIGH, CFG_DATA_BITS'(c.still_high_sq));
        set_reg(REG_PICKUP_WINDOW, CFG_DATA_BITS'(c.pickup_window_us));
        set_reg(REG_PICKUP_COUNT, CFG_DATA_BITS'(c.pickup_count));
    endtask

    // Mostly complete drop sequences with random content, mixed with raw samples.
    task automatic run_random(int budget, int lo, int hi, int latch_len, int odd);
        int stop_at;
        int motion_pct;
        int latch_left;
        tick_lo = lo;
        tick_hi = hi;
        odd_time_permille = odd;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 3)) send_kind(SK_STILL);
                repeat ($urandom_range(1, 12)) send_kind(SK_FREEFALL);
                if ($urandom_range(0, 3) == 0) send_kind(SK_STILL);
                if ($urandom_range(0, 4) == 0) begin
                    cur_time += TIME_W'(sb.cfg.impact_window_us) + 1;
                end
                send_kind(SK_IMPACT);
                motion_pct = $urandom_range(0, 100);
                latch_left = $urandom_range(5, latch_len);
                while (latch_left > 0 && items_sent < stop_at) begin
                    send_kind(($urandom_range(1, 100) <= motion_pct) ? SK_MOTION : SK_STILL);
                    latch_left--;
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_kind(SK_ANY);
            end
        end
    endtask

    initial begin
        t_cfg     c;
        t_cfg_idx idx;
        int       lo;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_FREEFALL_LEVEL;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        i_sample_time_us = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_sample(-32768, -32768, -32768, '0);
        send_sample(32767, 32767, 32767, TMAX);
        send_sample(0, 0, 0, 1000);
        send_sample(0, 0, -1, 500);
        send_sample(255, -255, 0, 200000);
        send_sample(0, 0, 0, TMAX - 100);
        send_sample(32767, 0, 0, TMAX - 50);
        send_sample(0, 0, 0, 100);
        send_sample(2500, 0, 0, TMAX - 40);
        send_sample(-32768, 0, 0, TMAX - 30);
        send_sample(0, -32768, 0, TMAX);
        settle();
        set_reg(REG_PICKUP_WINDOW, '0);
        set_reg(REG_PICKUP_COUNT, 1);
        send_sample(0, 0, 0, TMAX);
        send_sample(0, 0, 0, 10);
        send_sample(0, 0, 0, 150010);
        send_sample(0, 0, 0, 150011);
        send_sample(0, 0, 32767, 650011);
        send_sample(32767, 0, 0, 650010);
        send_sample(2400, 0, 0, 650010);
        send_sample(2400, 0, 0, 650011);

        load_config(CFG_RESET);
        run_random(300, 10000, 40000, 150, 30);

        c = CFG_RESET;
        c.freefall_time_us = 2000;
        c.impact_window_us = 5000;
        c.pickup_window_us = 20000;
        c.pickup_count = 5;
        load_config(c);
        run_random(500, 200, 1500, 60, 30);

        c.freefall_time_us = '0;
        c.impact_window_us = DUR_MAX;
        c.pickup_window_us = '0;
        c.pickup_count = '0;
        load_config(c);
        run_random(200, 200, 1500, 10, 30);

        // Every latched sample counts as motion, so the count saturates within a window.
        c = CFG_RESET;
        c.freefall_time_us = 2000;
        c.impact_window_us = 5000;
        c.still_low_sq = LEVEL_MAX;
        c.still_high_sq = LEVEL_MAX;
        c.pickup_window_us = 300000;
        c.pickup_count = 8'hFF;
        load_config(c);
        run_random(600, 400, 800, 600, 0);

        c.freefall_level_sq = '0;
        c.impact_level_sq = '0;
        c.still_low_sq = '0;
        c.still_high_sq = '0;
        c.freefall_time_us = DUR_MAX;
        c.impact_window_us = DUR_MAX;
        c.pickup_window_us = DUR_MAX;
        c.pickup_count = 8'hFF;
        load_config(c);
        run_random(100, 200, 1500, 20, 30);

        c.freefall_level_sq = LEVEL_MAX;
        c.impact_level_sq = LEVEL_MAX;
        c.still_low_sq = LEVEL_MAX;
        c.still_high_sq = LEVEL_MAX;
        c.freefall_time_us = '0;
        c.impact_window_us = '0;
        c.pickup_window_us = 1;
        c.pickup_count = 1;
        load_config(c);
        run_random(100, 200, 1500, 20, 30);

        repeat (3) begin
            settle();
            idx = idx.first();
            repeat (idx.num()) begin
                set_reg(idx, CFG_DATA_BITS'({$urandom, $urandom}));
                idx = idx.next();
            end
            lo = $urandom_range(1, 1000);
            run_random(50, lo, lo + $urandom_range(0, 50000), 30, 30);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
